// ----- rtl/core/hex_line_rasterizer_macros.svh -----
// ----------------------------------------------------------------------------
// hex_line_rasterizer_macros
// Assertion macros used by the checker file.
// ----------------------------------------------------------------------------
`ifndef HEX_LINE_RASTERIZER_MACROS_SVH
`define HEX_LINE_RASTERIZER_MACROS_SVH

// Consequent must hold on the following clock edge.
`define HLR_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("hex_line_rasterizer: next-cycle check failed");

// Consequent must hold on the same clock edge.
`define HLR_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("hex_line_rasterizer: same-cycle check failed");

`endif

// ----- rtl/core/hlr_pkg.sv -----
// ----------------------------------------------------------------------------
// hlr_pkg
// Command and status types shared by the hex line rasterizer controller
// and datapath.
// ----------------------------------------------------------------------------
package hlr_pkg;

  typedef struct packed {
    logic load;   // capture endpoints and cube deltas
    logic init;   // register distance, reset walk state
    logic step;   // advance one tile and load the output register
  } hlr_cmd_t;

  typedef struct packed {
    logic len_zero;    // endpoints are the same tile
    logic final_step;  // tile produced by the next step is the destination
  } hlr_status_t;

endpackage

// ----- rtl/core/hlr_ctrl.sv -----
// ----------------------------------------------------------------------------
// hlr_ctrl
// Sequencer for the hex line rasterizer: input handshake, setup, tile walk
// and output valid.
// ----------------------------------------------------------------------------
module hlr_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  output logic                out_valid,
  input  logic                out_stall,
  input  hlr_pkg::hlr_status_t status,
  output hlr_pkg::hlr_cmd_t    cmd
);
  import hlr_pkg::*;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SETUP = 2'd1;
  localparam logic [1:0] ST_RUN   = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;
  logic       out_valid_next;
  logic       adv;

  // output register is free or being drained this cycle
  assign adv      = !out_valid || !out_stall;
  assign in_stall = (state != ST_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_SETUP;
        end
      end
      ST_SETUP: begin
        cmd.init   = 1'b1;
        state_next = status.len_zero ? ST_IDLE : ST_RUN;
      end
      ST_RUN: begin
        if (adv) begin
          cmd.step = 1'b1;
          if (status.final_step) begin
            state_next = ST_IDLE;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    priority if (cmd.step) begin
      out_valid_next = 1'b1;
    end else if (!out_stall) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

// ----- rtl/core/hlr_dp.sv -----
// ----------------------------------------------------------------------------
// hlr_dp
// Datapath for the hex line rasterizer: cube deltas, hex distance, per-axis
// floor/remainder walk, half-away rounding, largest-error axis fixup and
// the output tile register.
// ----------------------------------------------------------------------------
module hlr_dp #(
  parameter int COORD_BITS = 5
) (
  input  logic                         clk,
  input  hlr_pkg::hlr_cmd_t            cmd,
  output hlr_pkg::hlr_status_t         status,
  input  logic signed [COORD_BITS-1:0] src_q,
  input  logic signed [COORD_BITS-1:0] src_r,
  input  logic signed [COORD_BITS-1:0] dst_q,
  input  logic signed [COORD_BITS-1:0] dst_r,
  output logic signed [COORD_BITS-1:0] tile_q,
  output logic signed [COORD_BITS-1:0] tile_r,
  output logic                         last
);
  import hlr_pkg::*;

  localparam int AW = COORD_BITS + 2;  // cube coordinate and delta
  localparam int LW = COORD_BITS + 1;  // distance, step index, remainder
  localparam int TW = LW + 2;          // remainder plus delta before fixup
  localparam int SW = AW + 1;          // sum of absolute deltas

  logic signed [AW-1:0] src   [3];
  logic signed [AW-1:0] del   [3];
  logic signed [AW-1:0] fl    [3];
  logic        [LW-1:0] rm    [3];
  logic        [LW-1:0] len;
  logic        [LW-1:0] idx;

  logic signed [AW-1:0] ld_src [3];
  logic signed [AW-1:0] ld_del [3];
  logic        [AW-1:0] abs_del [3];
  logic        [SW-1:0] abs_sum;
  logic        [LW-1:0] len_calc;

  logic signed [TW-1:0] acc    [3];
  logic signed [AW-1:0] fl_n   [3];
  logic        [LW-1:0] rm_n   [3];
  logic        [LW:0]   twice  [3];
  logic                 up     [3];
  logic signed [AW-1:0] res    [3];
  logic        [LW-1:0] err    [3];
  logic        [LW-1:0] idx_n;

  always_comb begin
    ld_src[0] = $signed({{2{src_q[COORD_BITS-1]}}, src_q});
    ld_src[1] = $signed({{2{src_r[COORD_BITS-1]}}, src_r});
    ld_src[2] = -ld_src[0] - ld_src[1];
    ld_del[0] = $signed({{2{dst_q[COORD_BITS-1]}}, dst_q}) - ld_src[0];
    ld_del[1] = $signed({{2{dst_r[COORD_BITS-1]}}, dst_r}) - ld_src[1];
    ld_del[2] = -ld_del[0] - ld_del[1];
  end

  // distance from the registered deltas; sum is always even
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      abs_del[k] = del[k][AW-1] ? AW'(-del[k]) : AW'(del[k]);
    end
    abs_sum  = SW'(abs_del[0]) + SW'(abs_del[1]) + SW'(abs_del[2]);
    len_calc = abs_sum[LW:1];
  end

  // per axis: value = fl + rm/len with 0 <= rm < len; |del| <= len keeps
  // the fixup to one add or subtract
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      acc[k] = $signed({2'b00, rm[k]}) + TW'(del[k]);
      if (acc[k] >= $signed({2'b00, len})) begin
        rm_n[k] = LW'(acc[k] - $signed({2'b00, len}));
        fl_n[k] = fl[k] + AW'(1);
      end else if (acc[k] < 0) begin
        rm_n[k] = LW'(acc[k] + $signed({2'b00, len}));
        fl_n[k] = fl[k] - AW'(1);
      end else begin
        rm_n[k] = LW'(acc[k]);
        fl_n[k] = fl[k];
      end
      twice[k] = {rm_n[k], 1'b0};
      // a tie rounds up only when the value is positive
      up[k]  = (twice[k] > {1'b0, len}) ||
               ((twice[k] == {1'b0, len}) && !fl_n[k][AW-1]);
      res[k] = up[k] ? (fl_n[k] + AW'(1)) : fl_n[k];
      err[k] = up[k] ? (len - rm_n[k]) : rm_n[k];
    end
    if ((err[0] > err[1]) && (err[0] > err[2])) begin
      res[0] = -res[1] - res[2];
    end else if (err[1] > err[2]) begin
      res[1] = -res[0] - res[2];
    end
  end

  assign idx_n             = idx + LW'(1);
  assign status.len_zero   = (len_calc == '0);
  assign status.final_step = (idx_n == len);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      for (int k = 0; k < 3; k++) begin
        src[k] <= ld_src[k];
        del[k] <= ld_del[k];
      end
    end
    if (cmd.init) begin
      len <= len_calc;
      idx <= '0;
      for (int k = 0; k < 3; k++) begin
        fl[k] <= src[k];
        rm[k] <= '0;
      end
    end
    if (cmd.step) begin
      idx <= idx_n;
      for (int k = 0; k < 3; k++) begin
        fl[k] <= fl_n[k];
        rm[k] <= rm_n[k];
      end
      tile_q <= res[0][COORD_BITS-1:0];
      tile_r <= res[1][COORD_BITS-1:0];
      last   <= status.final_step;
    end
  end

endmodule

// ----- rtl/core/hex_line_rasterizer.sv -----
// ----------------------------------------------------------------------------
// hex_line_rasterizer
// Hex grid line drawing between two axial tiles, one tile per output item.
// ----------------------------------------------------------------------------
// One input item (source and destination tile) produces d output items,
// where d is the hex distance: the d-1 tiles along the line, then the
// destination with last set. Equal tiles produce no output. An item is
// accepted, then a setup state forms the distance, then the walk produces
// one tile per cycle while the output is not stalled, from the incremental
// floor/remainder walk of the three cube axes; an output stall holds the
// walk. The next item is accepted while the destination tile still waits
// in the output register.
module hex_line_rasterizer #(
  parameter int COORD_BITS = 5
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic signed [COORD_BITS-1:0] src_q,
  input  logic signed [COORD_BITS-1:0] src_r,
  input  logic signed [COORD_BITS-1:0] dst_q,
  input  logic signed [COORD_BITS-1:0] dst_r,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic signed [COORD_BITS-1:0] tile_q,
  output logic signed [COORD_BITS-1:0] tile_r,
  output logic                         last
);
  import hlr_pkg::*;

  hlr_cmd_t    cmd;
  hlr_status_t status;

  hlr_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  hlr_dp #(
    .COORD_BITS (COORD_BITS)
  ) u_dp (
    .clk    (clk),
    .cmd    (cmd),
    .status (status),
    .src_q  (src_q),
    .src_r  (src_r),
    .dst_q  (dst_q),
    .dst_r  (dst_r),
    .tile_q (tile_q),
    .tile_r (tile_r),
    .last   (last)
  );

endmodule

// ----- rtl/core/hlr_checker.sv -----
// ----------------------------------------------------------------------------
// hlr_checker
// Port-level checks for the hex line rasterizer, bound to the top level.
// ----------------------------------------------------------------------------
`include "hex_line_rasterizer_macros.svh"

module hlr_checker #(
  parameter int COORD_BITS = 5
) (
  input logic                         clk,
  input logic                         rst,
  input logic                         in_valid,
  input logic                         in_stall,
  input logic                         out_valid,
  input logic                         out_stall,
  input logic signed [COORD_BITS-1:0] tile_q,
  input logic signed [COORD_BITS-1:0] tile_r,
  input logic                         last
);

  // a stalled tile holds
  `HLR_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(tile_q) && $stable(tile_r) && $stable(last))

  // an accepted item keeps the input side busy for its setup cycle
  `HLR_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall)

  // tiles before the destination are only produced while the line is active
  `HLR_ASSERT_NOW(a_mid_tile_busy, out_valid && !last, in_stall)

  // no tile appears directly after an idle cycle with nothing pending
  `HLR_ASSERT_NEXT(a_no_spurious_tile, !in_stall && !in_valid && !out_valid, !out_valid)

endmodule

bind hex_line_rasterizer hlr_checker #(.COORD_BITS(COORD_BITS)) u_hlr_checker (.*);
